@@ sv/skt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants for the sorted key table: action and status
// codes, controller states and the per-cell control bundle.
// ----------------------------------------------------------------------------
package skt_pkg;

    // Default table size and fixed field widths
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KEY_W           = 30;
    localparam int ACT_W           = 2;
    localparam int STAT_W          = 2;
    localparam int POS_W           = 6;
    localparam int CNT_OUT_W       = 7;

    // Request actions (the unused code acts as a search)
    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_SEARCH = 2'd2,
        ACT_ALIAS  = 2'd3
    } action_t;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_DONE = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY
    } state_t;

    // Control broadcast to every cell
    typedef struct packed {
        logic cmp_en;   // capture compare flags against the request key
        logic ins_en;   // open a slot at the insert point, shift larger keys up
        logic rem_en;   // close the slot of the matched key, shift larger down
    } cell_ctl_t;

endpackage

@@ sv/skt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_cell
// One slot of the sorted table: holds a key and an occupied bit, compares
// against the request key and shifts to or from its neighbors on update.
// ----------------------------------------------------------------------------
module skt_cell
    import skt_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_ctl_t        ctl,
    input  logic [KEY_W-1:0] req_key,
    input  logic [KEY_W-1:0] left_key,
    input  logic             left_valid,
    input  logic             left_lt,
    input  logic [KEY_W-1:0] right_key,
    input  logic             right_valid,
    output logic [KEY_W-1:0] key,
    output logic             valid,
    output logic             lt,
    output logic             eq
);

    logic [KEY_W-1:0] key_reg, key_next;
    logic             valid_reg, valid_next;
    logic             lt_reg, eq_reg;

    // Occupied bit is control state; key and flags are payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        key_reg <= key_next;
        if (ctl.cmp_en) begin
            lt_reg <= valid_reg && (key_reg < req_key);
            eq_reg <= valid_reg && (key_reg == req_key);
        end
    end

    // Shift decision is local: cells below the insert/remove point hold
    always_comb begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctl.ins_en && !lt_reg) begin
            if (left_lt) begin
                key_next   = req_key;
                valid_next = 1'b1;
            end else begin
                key_next   = left_key;
                valid_next = left_valid;
            end
        end else if (ctl.rem_en && !lt_reg) begin
            key_next   = right_key;
            valid_next = right_valid;
        end
    end

    assign key   = key_reg;
    assign valid = valid_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

@@ sv/skt_pos_enc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pos_enc
// One-hot to binary encoder for the slot marked by the cell row.
// ----------------------------------------------------------------------------
module skt_pos_enc
    import skt_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic [DEPTH-1:0] hot,
    output logic [IDX_W-1:0] idx
);

    // OR together the indexes of set bits; at most one is set
    always_comb begin
        idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (hot[i]) begin
                idx = idx | IDX_W'(i);
            end
        end
    end

endmodule

@@ sv/sorted_key_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table
// Sorted table of unique keys with insert, remove and search, one result
// per request, built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Each request passes a capture, a compare pass and a shift pass over the cell
// row; the next one is taken once the shift pass is done, and that pass waits
// while an older result is still untaken. A new request is taken while the
// previous result waits. Reset (synchronous, active low) empties the table at
// once by clearing the per-cell occupied bits and the entry count.
// ----------------------------------------------------------------------------
module sorted_key_table
    import skt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ACT_W-1:0]     s_action,
    input  logic [KEY_W-1:0]     s_key,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STAT_W-1:0]    m_status,
    output logic [POS_W-1:0]     m_position,
    output logic [CNT_OUT_W-1:0] m_entry_count
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    state_t               state_reg, state_next;
    logic [ACT_W-1:0]     act_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [CNT_W-1:0]     held_count_reg, held_count_next;
    logic                 m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]    m_status_reg, m_status_next;
    logic [POS_W-1:0]     m_position_reg, m_position_next;
    logic [CNT_OUT_W-1:0] m_count_reg, m_count_next;

    cell_ctl_t            ctl;
    logic [KEY_W-1:0]     cell_key   [TABLE_DEPTH];
    logic [KEY_W-1:0]     left_key   [TABLE_DEPTH];
    logic [KEY_W-1:0]     right_key  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] cell_valid, cell_lt, cell_eq;
    logic [TABLE_DEPTH-1:0] left_valid, left_lt, right_valid, edge_hot;
    logic [IDX_W-1:0]     at_idx;

    logic s_fire, out_free, present, full, do_ins, do_rem;
    logic [IDX_W+POS_W-1:0]     pos_wide;
    logic [CNT_W+CNT_OUT_W-1:0] cnt_wide;

    // Neighbor wiring along the row; ends see an always-smaller left, empty right
    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_row
            if (g == 0) begin : g_first
                assign left_key[g]   = '0;
                assign left_valid[g] = 1'b1;
                assign left_lt[g]    = 1'b1;
            end else begin : g_mid_l
                assign left_key[g]   = cell_key[g-1];
                assign left_valid[g] = cell_valid[g-1];
                assign left_lt[g]    = cell_lt[g-1];
            end
            if (g == TABLE_DEPTH - 1) begin : g_last
                assign right_key[g]   = '0;
                assign right_valid[g] = 1'b0;
            end else begin : g_mid_r
                assign right_key[g]   = cell_key[g+1];
                assign right_valid[g] = cell_valid[g+1];
            end

            // Insert/remove point: first cell whose key is not below the request
            assign edge_hot[g] = left_lt[g] & ~cell_lt[g];

            skt_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctl         (ctl),
                .req_key     (key_reg),
                .left_key    (left_key[g]),
                .left_valid  (left_valid[g]),
                .left_lt     (left_lt[g]),
                .right_key   (right_key[g]),
                .right_valid (right_valid[g]),
                .key         (cell_key[g]),
                .valid       (cell_valid[g]),
                .lt          (cell_lt[g]),
                .eq          (cell_eq[g])
            );
        end
    endgenerate

    skt_pos_enc #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_pos_enc (
        .hot (edge_hot),
        .idx (at_idx)
    );

    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign present  = |cell_eq;
    assign full     = (held_count_reg == CNT_W'(TABLE_DEPTH));
    assign do_ins   = (act_reg == ACT_INSERT) && !present && !full;
    assign do_rem   = (act_reg == ACT_REMOVE) && present;
    assign pos_wide = {{POS_W{1'b0}}, at_idx};

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            held_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            held_count_reg <= held_count_next;
            m_valid_reg    <= m_valid_next;
        end
        if (s_fire) begin
            act_reg <= s_action;
            key_reg <= s_key;
        end
        m_status_reg   <= m_status_next;
        m_position_reg <= m_position_next;
        m_count_reg    <= m_count_next;
    end

    // Controller: capture, compare, then update and load the result
    always_comb begin
        state_next      = state_reg;
        held_count_next = held_count_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_position_next = m_position_reg;
        m_count_next    = m_count_reg;
        ctl             = '0;
        s_ready         = 1'b0;
        cnt_wide        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                ctl.cmp_en = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (out_free) begin
                    ctl.ins_en = do_ins;
                    ctl.rem_en = do_rem;
                    if (do_ins) begin
                        held_count_next = held_count_reg + 1'b1;
                    end else if (do_rem) begin
                        held_count_next = held_count_reg - 1'b1;
                    end
                    if ((act_reg == ACT_INSERT) && present) begin
                        m_status_next = STAT_MISS;
                    end else if ((act_reg == ACT_INSERT) && full) begin
                        m_status_next = STAT_FULL;
                    end else if (!present && (act_reg != ACT_INSERT)) begin
                        m_status_next = STAT_MISS;
                    end else begin
                        m_status_next = STAT_DONE;
                    end
                    m_position_next = (do_ins || present) && !(act_reg == ACT_INSERT
                                      && present) ? pos_wide[POS_W-1:0] : '0;
                    cnt_wide        = {{CNT_OUT_W{1'b0}}, held_count_next};
                    m_count_next    = cnt_wide[CNT_OUT_W-1:0];
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_position    = m_position_reg;
    assign m_entry_count = m_count_reg;

    // Occupied cells always match the entry count
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_W'($countones(cell_valid)) == held_count_reg)
        else $error("cell occupancy disagrees with entry count");

    // Keys are unique, so at most one cell matches
    a_unique_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_APPLY) |-> $onehot0(cell_eq))
        else $error("more than one cell matches the request key");

    // A full report only comes from a full table
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == STAT_FULL)) |-> full)
        else $error("table full reported while space remains");

    // A failed action never reports a position
    a_fail_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STAT_DONE)) |-> (m_position == '0))
        else $error("nonzero position on failed action");

endmodule

@@ verif/sorted_key_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_tb
// Self-checking bench for the sorted key table. A shadow copy of the table
// predicts status, position and entry count for every request transfer. A
// directed pass covers empty, edge and duplicate cases. Random rounds then
// fill the table past full, churn it and drain it, under three idle mixes.
// ----------------------------------------------------------------------------
module sorted_key_table_tb;
    import skt_pkg::*;

    localparam int    DEPTH     = TABLE_DEPTH_DEF;
    localparam int    KEY_MAX   = 999999999;
    localparam int    SETTLE    = 12;
    localparam int    MAX_PRINT = 40;

    typedef struct {
        action_t          action;
        logic [KEY_W-1:0] key;
    } table_request_t;

    typedef struct {
        action_t              action;
        logic [KEY_W-1:0]     key;
        status_t              status;
        logic [POS_W-1:0]     position;
        logic [CNT_OUT_W-1:0] entry_count;
    } table_outcome_t;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [ACT_W-1:0]     s_action = ACT_SEARCH;
    logic [KEY_W-1:0]     s_key    = '0;
    logic                 m_valid;
    logic                 m_ready  = 1'b0;
    logic [STAT_W-1:0]    m_status;
    logic [POS_W-1:0]     m_position;
    logic [CNT_OUT_W-1:0] m_entry_count;

    // Shadow table and bookkeeping
    logic [KEY_W-1:0]     shadow_keys [DEPTH];
    int                   shadow_fill;
    table_request_t       request_queue [$];
    table_outcome_t       expected_outcomes [$];
    logic [KEY_W-1:0]     key_pool [$];

    int send_idle_pct = 7;
    int recv_idle_pct = 59;
    int error_count   = 0;
    int requests_sent = 0;
    int results_seen  = 0;
    int full_rejects  = 0;
    int dup_rejects   = 0;
    int key_misses    = 0;
    int peak_fill     = 0;

    sorted_key_table dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_key         (s_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_position    (m_position),
        .m_entry_count (m_entry_count)
    );

    always #1 aclk = ~aclk;

    // Apply one request to the shadow table and return the outcome it gives
    function automatic table_outcome_t apply_to_table(action_t act, logic [KEY_W-1:0] k);
        table_outcome_t res;
        int             at;
        bit             found;
        res.action      = act;
        res.key         = k;
        res.status      = STAT_DONE;
        res.position    = '0;
        at = 0;
        while (at < shadow_fill && shadow_keys[at] < k)
            at++;
        found = (at < shadow_fill) && (shadow_keys[at] == k);
        case (act)
            ACT_INSERT: begin
                if (found) begin
                    res.status = STAT_MISS;
                    dup_rejects++;
                end else if (shadow_fill >= DEPTH) begin
                    res.status = STAT_FULL;
                    full_rejects++;
                end else begin
                    for (int j = shadow_fill; j > at; j--)
                        shadow_keys[j] = shadow_keys[j-1];
                    shadow_keys[at] = k;
                    shadow_fill++;
                    res.position = at[POS_W-1:0];
                end
            end
            ACT_REMOVE: begin
                if (!found) begin
                    res.status = STAT_MISS;
                    key_misses++;
                end else begin
                    for (int j = at; j + 1 < shadow_fill; j++)
                        shadow_keys[j] = shadow_keys[j+1];
                    shadow_fill--;
                    res.position = at[POS_W-1:0];
                end
            end
            // search, and the spare code that behaves as one
            default: begin
                if (found) begin
                    res.position = at[POS_W-1:0];
                end else begin
                    res.status = STAT_MISS;
                    key_misses++;
                end
            end
        endcase
        if (shadow_fill > peak_fill)
            peak_fill = shadow_fill;
        res.entry_count = shadow_fill[CNT_OUT_W-1:0];
        return res;
    endfunction

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINT)
            $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic push_request(input action_t act, input logic [KEY_W-1:0] k);
        table_request_t req;
        req.action = act;
        req.key    = k;
        request_queue.push_back(req);
    endtask

    function automatic logic [KEY_W-1:0] fresh_key();
        return KEY_W'($urandom_range(KEY_MAX, 0));
    endfunction

    // Pool key most of the time, an unrelated key otherwise
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(99) < 92)
            return key_pool[$urandom_range(key_pool.size() - 1, 0)];
        return fresh_key();
    endfunction

    function automatic action_t pick_action();
        int roll;
        roll = $urandom_range(99);
        if (roll < 32)
            return ACT_INSERT;
        if (roll < 64)
            return ACT_REMOVE;
        if (roll < 96)
            return ACT_SEARCH;
        return ACT_ALIAS;
    endfunction

    // Hold new requests back until every pending result is back
    task automatic wait_for_drain();
        while (request_queue.size() != 0 || s_valid || expected_outcomes.size() != 0)
            @(posedge aclk);
    endtask

    // Two rounds of fill past full, mixed churn, then a drain of the pool
    task automatic run_phase(input int send_pct, input int recv_pct);
        int                pool_size;
        int                swap_idx;
        logic [KEY_W-1:0]  tmp;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (2) begin
            // new key pool, larger than the table, with neighbors and extremes
            key_pool.delete();
            pool_size = $urandom_range(100, 72);
            for (int i = 0; i < pool_size; i++) begin
                if (i > 0 && $urandom_range(99) < 25)
                    tmp = (key_pool[i-1] >= KEY_MAX) ? KEY_W'(key_pool[i-1] - 1)
                                                     : KEY_W'(key_pool[i-1] + 1);
                else if ($urandom_range(99) < 5)
                    tmp = $urandom_range(1) ? KEY_W'(KEY_MAX) : '0;
                else
                    tmp = fresh_key();
                key_pool.push_back(tmp);
            end
            // shuffle so fills land in random order
            for (int i = pool_size - 1; i > 0; i--) begin
                swap_idx           = $urandom_range(i, 0);
                tmp                = key_pool[i];
                key_pool[i]        = key_pool[swap_idx];
                key_pool[swap_idx] = tmp;
            end
            // fill: insert every pool key, with some noise mixed in
            foreach (key_pool[i]) begin
                if ($urandom_range(99) < 15)
                    push_request(pick_action(), pick_key());
                push_request(ACT_INSERT, key_pool[i]);
            end
            // churn
            repeat (120)
                push_request(pick_action(), pick_key());
            // drain: remove the pool in a different order (stride prime to the size)
            for (int i = 0; i < pool_size; i++) begin
                swap_idx = (i * 53 + 11) % pool_size;
                if ($urandom_range(99) < 15)
                    push_request(ACT_SEARCH, pick_key());
                push_request(ACT_REMOVE, key_pool[swap_idx]);
            end
        end
        wait_for_drain();
    endtask

    // Request driver: prediction is taken at each request transfer
    always @(posedge aclk) begin : drive_requests
        table_request_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_outcomes.push_back(apply_to_table(action_t'(s_action), s_key));
                requests_sent++;
            end
            if (!s_valid || s_ready) begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req = request_queue.pop_front();
                    s_action <= req.action;
                    s_key    <= req.key;
                    s_valid  <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and checker
    always @(posedge aclk) begin : check_results
        table_outcome_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_outcomes.size() == 0) begin
                    report_error($sformatf("unexpected result status=%0d pos=%0d count=%0d",
                                           m_status, m_position, m_entry_count));
                end else begin
                    want = expected_outcomes.pop_front();
                    if (m_status !== want.status)
                        report_error($sformatf("%s key %0d: status %0d, expected %0d",
                                               want.action.name(), want.key, m_status,
                                               want.status));
                    if (m_position !== want.position)
                        report_error($sformatf("%s key %0d: position %0d, expected %0d",
                                               want.action.name(), want.key, m_position,
                                               want.position));
                    if (m_entry_count !== want.entry_count)
                        report_error($sformatf("%s key %0d: entry_count %0d, expected %0d",
                                               want.action.name(), want.key, m_entry_count,
                                               want.entry_count));
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Reset and stimulus
    initial begin
        shadow_fill = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table
        push_request(ACT_SEARCH, '0);
        push_request(ACT_REMOVE, 30'd5);
        push_request(ACT_ALIAS,  30'd7);
        // extremes and neighbors, inserted out of order
        push_request(ACT_INSERT, 30'd500000000);
        push_request(ACT_INSERT, '0);
        push_request(ACT_INSERT, 30'(KEY_MAX));
        push_request(ACT_INSERT, '0);
        push_request(ACT_INSERT, 30'd499999999);
        push_request(ACT_INSERT, 30'd500000001);
        push_request(ACT_SEARCH, 30'(KEY_MAX));
        push_request(ACT_ALIAS,  '0);
        push_request(ACT_SEARCH, 30'd500000000);
        push_request(ACT_SEARCH, 30'd12345);
        // remove from middle, front and back
        push_request(ACT_REMOVE, 30'd500000000);
        push_request(ACT_REMOVE, '0);
        push_request(ACT_REMOVE, 30'(KEY_MAX));
        push_request(ACT_REMOVE, 30'(KEY_MAX));
        // all low key bits, then the top bit alone
        push_request(ACT_INSERT, 30'h1FFFFFFF);
        push_request(ACT_INSERT, 30'h20000000);
        push_request(ACT_ALIAS,  30'h20000000);
        // back to empty
        push_request(ACT_REMOVE, 30'd499999999);
        push_request(ACT_REMOVE, 30'd500000001);
        push_request(ACT_REMOVE, 30'h1FFFFFFF);
        push_request(ACT_REMOVE, 30'h20000000);
        push_request(ACT_SEARCH, 30'h20000000);
        wait_for_drain();

        run_phase(7, 59);
        run_phase(59, 7);
        run_phase(0, 0);

        repeat (SETTLE) @(posedge aclk);
        $display("Covered %0d requests and %0d results; table peaked at %0d of %0d entries.",
                 requests_sent, results_seen, peak_fill, DEPTH);
        $display("Rejects seen: %0d table full, %0d duplicate insert, %0d key not found.",
                 full_rejects, dup_rejects, key_misses);
        if (error_count == 0) begin
            $display("** sorted_key_table: PASSED **");
        end else begin
            $display("%0d mismatches", error_count);
            $display("** sorted_key_table: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Timeout with %0d results still pending", expected_outcomes.size());
        $display("** sorted_key_table: FAILED **");
        $finish;
    end

endmodule
